// ===== rtl/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define VTCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define VTCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/vtcm_pkg.sv =====
// shared types, constants and arithmetic helpers of the texture coordinate mapper
`timescale 1ns / 1ps
package vtcm_pkg;

    localparam int ANGLE_ITER_DEF = 16;
    localparam int TAB_LEN        = 24;
    localparam int SQRT_STEPS     = 32;
    localparam int MID_DEPTH      = 4;
    localparam int CW             = 36;
    localparam int ONE_FX         = 65536;

    localparam logic [2:0] MODE_PLANAR = 3'd0;
    localparam logic [2:0] MODE_SPHERE = 3'd1;
    localparam logic [2:0] MODE_CYL    = 3'd2;
    localparam logic [2:0] MODE_DISC   = 3'd3;
    localparam logic [2:0] MODE_NONE   = 3'd4;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_MAT0 = 3'd1;
    localparam logic [2:0] REG_MAT1 = 3'd2;
    localparam logic [2:0] REG_MAT2 = 3'd3;
    localparam logic [2:0] REG_MAT3 = 3'd4;
    localparam logic [2:0] REG_MAT4 = 3'd5;
    localparam logic [2:0] REG_MAT5 = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               in_last;
    } vtcm_in_t;

    typedef struct packed {
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
        logic               out_last;
    } vtcm_out_t;

    // transformed vertex between front and back
    typedef struct packed {
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] t2;
        logic               last;
    } vtcm_mid_t;

    typedef struct packed {
        logic full;
        logic empty;
    } vtcm_qstat_t;

    // per-item payload along the back pipeline
    typedef struct packed {
        logic [2:0]         mode;
        logic               last;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
    } vtcm_pl_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [31:0]          acc;
        logic                 zero;
    } vtcm_cs_t;

    function automatic logic [31:0] atan_tab(input int i);
        logic [31:0] r;
        unique case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517C;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A2F;
            19: r = 32'h00000517;
            20: r = 32'h0000028B;
            21: r = 32'h00000145;
            22: r = 32'h000000A2;
            23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -50'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // (c + 1.0) / 2, floor
    function automatic logic signed [31:0] half_plus(input logic signed [31:0] c);
        logic signed [32:0] s;
        s = {c[31], c} + 33'sd65536;
        return s[32:1];
    endfunction

    function automatic vtcm_cs_t cordic_init(input logic signed [CW-1:0] x,
                                             input logic signed [CW-1:0] y);
        vtcm_cs_t s;
        s.zero = (x == '0) && (y == '0);
        if (x[CW-1])
        begin
            s.x   = -x;
            s.y   = -y;
            s.acc = 32'h80000000;
        end
        else
        begin
            s.x   = x;
            s.y   = y;
            s.acc = 32'h0;
        end
        return s;
    endfunction

    function automatic vtcm_cs_t cordic_step(input vtcm_cs_t s, input int i);
        vtcm_cs_t             r;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        x = s.x;
        y = s.y;
        r.zero = s.zero;
        if (!y[CW-1] && (y != '0))
        begin
            r.x   = x + (y >>> i);
            r.y   = y - (x >>> i);
            r.acc = s.acc + atan_tab(i);
        end
        else
        begin
            r.x   = x - (y >>> i);
            r.y   = y + (x >>> i);
            r.acc = s.acc - atan_tab(i);
        end
        return r;
    endfunction

    // round the turn accumulator to 16 bits
    function automatic logic [15:0] cordic_angle(input vtcm_cs_t s);
        logic [31:0] rnd;
        rnd = s.acc + 32'h00008000;
        return s.zero ? 16'h0 : rnd[31:16];
    endfunction

endpackage

// ===== rtl/vtcm_front.sv =====
// front end: configuration registers and the affine transform
`timescale 1ns / 1ps
module vtcm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  vtcm_pkg::vtcm_in_t in_item,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    output logic [2:0]         mode,
    output logic               q_wr,
    output vtcm_pkg::vtcm_mid_t q_item,
    input  vtcm_pkg::vtcm_qstat_t q_stat
);
    import vtcm_pkg::*;

    logic [2:0]         mode_reg;
    logic [63:0]        mat_reg [0:5];
    logic signed [31:0] coef [0:11];
    logic signed [31:0] pos [0:2];

    logic               f1_valid_reg;
    logic               f1_last_reg;
    logic signed [63:0] f1_prod_reg [0:8];
    logic               f2_valid_reg;
    vtcm_mid_t          f2_item_reg;
    vtcm_mid_t          f2_item_next;
    logic               front_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            mat_reg[0] <= 64'(ONE_FX);
            mat_reg[1] <= 64'd0;
            mat_reg[2] <= 64'(ONE_FX);
            mat_reg[3] <= 64'd0;
            mat_reg[4] <= 64'(ONE_FX);
            mat_reg[5] <= 64'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE: mode_reg   <= cfg_data[2:0];
                REG_MAT0: mat_reg[0] <= cfg_data;
                REG_MAT1: mat_reg[1] <= cfg_data;
                REG_MAT2: mat_reg[2] <= cfg_data;
                REG_MAT3: mat_reg[3] <= cfg_data;
                REG_MAT4: mat_reg[4] <= cfg_data;
                REG_MAT5: mat_reg[5] <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign mode = mode_reg;

    for (genvar k = 0; k < 12; k++)
    begin : g_coef
        if (k % 2 == 1)
        begin : g_hi
            assign coef[k] = mat_reg[k/2][63:32];
        end
        else
        begin : g_lo
            assign coef[k] = mat_reg[k/2][31:0];
        end
    end

    assign pos[0] = in_item.pos_x;
    assign pos[1] = in_item.pos_y;
    assign pos[2] = in_item.pos_z;

    // stalls only when the transformed item cannot leave
    assign front_en = !(f2_valid_reg && q_stat.full);
    assign full     = !front_en;
    assign q_wr     = f2_valid_reg && !q_stat.full;
    assign q_item   = f2_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (front_en)
        begin
            f1_valid_reg <= push;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            always_ff @(posedge clk)
            begin
                if (front_en)
                    f1_prod_reg[3*r+j] <= pos[r] * coef[3*r+j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_en)
        begin
            f1_last_reg <= in_item.in_last;
            f2_item_reg <= f2_item_next;
        end
    end

    always_comb
    begin
        logic signed [49:0] s [0:2];
        for (int j = 0; j < 3; j++)
        begin
            s[j] = 50'(f1_prod_reg[j] >>> 16) + 50'(f1_prod_reg[3+j] >>> 16)
                 + 50'(f1_prod_reg[6+j] >>> 16) + 50'(coef[9+j]);
        end
        f2_item_next.t0   = sat32(s[0]);
        f2_item_next.t1   = sat32(s[1]);
        f2_item_next.t2   = sat32(s[2]);
        f2_item_next.last = f1_last_reg;
    end

endmodule

// ===== rtl/vtcm_queue.sv =====
// short queue of transformed vertices between front and back
`timescale 1ns / 1ps
module vtcm_queue #(
    parameter int DEPTH = vtcm_pkg::MID_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr,
    input  vtcm_pkg::vtcm_mid_t   wr_item,
    input  logic                  rd,
    output vtcm_pkg::vtcm_mid_t   rd_item,
    output vtcm_pkg::vtcm_qstat_t stat
);
    import vtcm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    vtcm_mid_t       mem_reg [0:DEPTH-1];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign stat.full  = (cnt_reg == CNTW'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr && !stat.full;
    assign do_rd      = rd && !stat.empty;
    assign rd_item    = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_item;
    end

endmodule

// ===== rtl/vtcm_back.sv =====
// back end: radius square root, two angle units and result register
`timescale 1ns / 1ps
module vtcm_back #(
    parameter int ANGLE_ITERATIONS = vtcm_pkg::ANGLE_ITER_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [2:0]            mode,
    output logic                  q_rd,
    input  vtcm_pkg::vtcm_mid_t   q_item,
    input  vtcm_pkg::vtcm_qstat_t q_stat,
    output logic                  empty,
    input  logic                  pop,
    output vtcm_pkg::vtcm_out_t   out_item
);
    import vtcm_pkg::*;

    localparam int N = ANGLE_ITERATIONS;

    logic               en;
    logic               s0_valid_reg;
    vtcm_pl_t           s0_pl_reg;
    logic signed [32:0] s0_ya_reg;
    logic [63:0]        s0_sqa_reg;
    logic [63:0]        s0_sqb_reg;

    logic               sv_reg  [0:SQRT_STEPS];
    vtcm_pl_t           spl_reg [0:SQRT_STEPS];
    logic signed [32:0] sya_reg [0:SQRT_STEPS];
    logic [63:0]        sn_reg  [0:SQRT_STEPS];
    logic [63:0]        sr_reg  [0:SQRT_STEPS];

    logic               cv_reg  [0:N];
    vtcm_pl_t           cpl_reg [0:N];
    logic [31:0]        crr_reg [0:N];
    vtcm_cs_t           cu_reg  [0:N];
    vtcm_cs_t           cw_reg  [0:N];

    logic               out_valid_reg;
    vtcm_out_t          out_reg;
    vtcm_out_t          out_next;

    logic signed [31:0] rad_b;
    logic signed [63:0] sqa;
    logic signed [63:0] sqb;

    assign en       = !out_valid_reg || pop;
    assign q_rd     = en && !q_stat.empty;
    assign empty    = !out_valid_reg;
    assign out_item = out_reg;

    // radius pairs x with z, or with y for the disc
    assign rad_b = (mode == MODE_DISC) ? q_item.t1 : q_item.t2;
    assign sqa   = q_item.t0 * q_item.t0;
    assign sqb   = rad_b * rad_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            sv_reg[0]     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg  <= q_rd;
            sv_reg[0]     <= s0_valid_reg;
            out_valid_reg <= cv_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_pl_reg.mode <= mode;
            s0_pl_reg.last <= q_item.last;
            s0_pl_reg.t0   <= q_item.t0;
            s0_pl_reg.t1   <= q_item.t1;
            s0_ya_reg      <= (mode == MODE_DISC) ? -33'(q_item.t1) : -33'(q_item.t2);
            s0_sqa_reg     <= sqa;
            s0_sqb_reg     <= sqb;
            spl_reg[0]     <= s0_pl_reg;
            sya_reg[0]     <= s0_ya_reg;
            sn_reg[0]      <= s0_sqa_reg + s0_sqb_reg;
            sr_reg[0]      <= 64'd0;
            out_reg        <= out_next;
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = sr_reg[k] + BIT;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_reg[k+1] <= 1'b0;
            else if (en)
                sv_reg[k+1] <= sv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                spl_reg[k+1] <= spl_reg[k];
                sya_reg[k+1] <= sya_reg[k];
                if (sn_reg[k] >= trial)
                begin
                    sn_reg[k+1] <= sn_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    sn_reg[k+1] <= sn_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= sv_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpl_reg[0] <= spl_reg[SQRT_STEPS];
            crr_reg[0] <= sr_reg[SQRT_STEPS][31:0];
            cu_reg[0]  <= cordic_init(CW'(spl_reg[SQRT_STEPS].t0),
                                      CW'(sya_reg[SQRT_STEPS]));
            cw_reg[0]  <= cordic_init(CW'(spl_reg[SQRT_STEPS].t1),
                                      CW'({1'b0, sr_reg[SQRT_STEPS][31:0]}));
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (en)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cpl_reg[i+1] <= cpl_reg[i];
                crr_reg[i+1] <= crr_reg[i];
                cu_reg[i+1]  <= cordic_step(cu_reg[i], i);
                cw_reg[i+1]  <= cordic_step(cw_reg[i], i);
            end
        end
    end

    always_comb
    begin
        logic [15:0] ang_u;
        logic [15:0] ang_v;
        logic [15:0] pol;
        ang_u = cordic_angle(cu_reg[N]);
        ang_v = cordic_angle(cw_reg[N]);
        // polar angle kept in [0, 1/2] turn
        if (ang_v >= 16'hC000)
            pol = 16'h0;
        else if (ang_v > 16'h8000)
            pol = 16'h8000;
        else
            pol = ang_v;
        out_next.out_last = cpl_reg[N].last;
        unique case (cpl_reg[N].mode)
            MODE_PLANAR:
            begin
                out_next.tex_u = half_plus(cpl_reg[N].t0);
                out_next.tex_v = half_plus(cpl_reg[N].t1);
            end
            MODE_SPHERE:
            begin
                out_next.tex_u = {16'h0, ang_u};
                out_next.tex_v = 32'(ONE_FX) - {15'h0, pol, 1'b0};
            end
            MODE_CYL:
            begin
                out_next.tex_u = {16'h0, ang_u};
                out_next.tex_v = half_plus(cpl_reg[N].t1);
            end
            MODE_DISC:
            begin
                out_next.tex_u = {16'h0, ang_u};
                out_next.tex_v = crr_reg[N][31] ? 32'sh7FFFFFFF : crr_reg[N];
            end
            default:
            begin
                out_next.tex_u = 32'sh0;
                out_next.tex_v = 32'sh0;
            end
        endcase
    end

endmodule

// ===== rtl/vertex_texture_coord_mapper_top.sv =====
// top level of the vertex texture coordinate mapper
//
//  channel   direction  handshake          payload
//  input     in         push / full        in_item   (vtcm_in_t)
//  result    out        empty / pop        out_item  (vtcm_out_t)
//  config    in         cfg_valid / ready  cfg_index, cfg_data
//
// one item per cycle sustained while results are popped; the back holds
// the 32-stage square root and the angle stages behind it
// the front (transform) and back stall separately across a 4-entry queue
// reset clears all valid state and loads identity matrix with mode none
// cfg_ready is always high
`timescale 1ns / 1ps
module vertex_texture_coord_mapper_top #(
    parameter int ANGLE_ITERATIONS = vtcm_pkg::ANGLE_ITER_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  vtcm_pkg::vtcm_in_t  in_item,
    output logic                empty,
    input  logic                pop,
    output vtcm_pkg::vtcm_out_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import vtcm_pkg::*;

    logic        q_wr;
    logic        q_rd;
    vtcm_mid_t   q_wr_item;
    vtcm_mid_t   q_rd_item;
    vtcm_qstat_t q_stat;
    logic [2:0]  mode;

    assign cfg_ready = 1'b1;

    vtcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mode      (mode),
        .q_wr      (q_wr),
        .q_item    (q_wr_item),
        .q_stat    (q_stat)
    );

    vtcm_queue #(
        .DEPTH (MID_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_wr_item),
        .rd      (q_rd),
        .rd_item (q_rd_item),
        .stat    (q_stat)
    );

    vtcm_back #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode),
        .q_rd     (q_rd),
        .q_item   (q_rd_item),
        .q_stat   (q_stat),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// ===== rtl/vtcm_checker.sv =====
// port-level checker for the mapper and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vtcm_port_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input vtcm_pkg::vtcm_in_t  in_item,
    input logic                empty,
    input logic                pop,
    input vtcm_pkg::vtcm_out_t out_item,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [2:0]          cfg_index,
    input logic [63:0]         cfg_data
);
    import vtcm_pkg::*;

    // a waiting result holds until taken
    `VTCM_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(out_item)), "result changed while waiting")

    // the config port never pushes back
    `VTCM_ASSERT(a_ready, clk, rst_n, cfg_ready, "config port not ready")

    // after reset nothing is waiting
    `VTCM_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> empty || !rst_n, "result present right after reset")

endmodule

bind vertex_texture_coord_mapper_top vtcm_port_checker u_chk (.*);

// ===== dv/vtcm_checker.sv =====
// checker of the texture coordinate mapper: predicts each result and compares it
`timescale 1ns / 1ps
module vtcm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  vtcm_pkg::vtcm_in_t  in_item,
    input  logic                empty,
    input  logic                pop,
    input  vtcm_pkg::vtcm_out_t out_item,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output int                  errors,
    output int                  pending
);
    import vtcm_pkg::*;

    // one entry per cordic stage, fractions of a turn
    localparam logic [31:0] TURN_STEP [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    logic [2:0]  mode_q;
    logic [63:0] mat_q [0:5];
    vtcm_out_t   uv_expected [$];

    assign pending = uv_expected.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint coef_at(input int k);
        logic [63:0] w;
        logic [31:0] h;
        w = mat_q[k / 2];
        h = (k % 2) ? w[63:32] : w[31:0];
        return longint'($signed(h));
    endfunction

    function automatic logic [15:0] turn_of(input longint yy, input longint xx);
        logic [31:0] acc;
        logic [31:0] rnd;
        longint      nx;
        longint      ny;
        acc = 32'h0;
        if (xx == 0 && yy == 0)
            return 16'h0;
        if (xx < 0)
        begin
            xx  = -xx;
            yy  = -yy;
            acc = 32'h80000000;
        end
        for (int i = 0; i < ANGLE_ITER_DEF; i++)
        begin
            if (yy > 0)
            begin
                nx  = xx + (yy >>> i);
                ny  = yy - (xx >>> i);
                acc = acc + TURN_STEP[i];
            end
            else
            begin
                nx  = xx - (yy >>> i);
                ny  = yy + (xx >>> i);
                acc = acc - TURN_STEP[i];
            end
            xx = nx;
            yy = ny;
        end
        rnd = acc + 32'h00008000;
        return rnd[31:16];
    endfunction

    function automatic longint dist_of(input longint a, input longint b);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_w;
        n     = 64'(a * a) + 64'(b * b);
        res   = 64'h0;
        bit_w = 64'h1 << 62;
        while (bit_w > n)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (n >= res + bit_w)
            begin
                n   = n - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return longint'(res);
    endfunction

    function automatic vtcm_out_t map_vertex(input vtcm_in_t v);
        vtcm_out_t   r;
        longint      p [0:2];
        longint      t [0:2];
        longint      u;
        longint      w;
        logic [15:0] a;
        p[0] = v.pos_x;
        p[1] = v.pos_y;
        p[2] = v.pos_z;
        for (int j = 0; j < 3; j++)
            t[j] = clamp32(((p[0] * coef_at(j)) >>> 16) + ((p[1] * coef_at(3 + j)) >>> 16)
                           + ((p[2] * coef_at(6 + j)) >>> 16) + coef_at(9 + j));
        u = 0;
        w = 0;
        case (mode_q)
            MODE_PLANAR:
            begin
                u = (t[0] + ONE_FX) >>> 1;
                w = (t[1] + ONE_FX) >>> 1;
            end
            MODE_SPHERE:
            begin
                u = turn_of(-t[2], t[0]);
                a = turn_of(dist_of(t[0], t[2]), t[1]);
                // polar angle wrapped to three quarters of a turn or more is zero, above a half is a half
                if (a >= 16'hC000)
                    a = 16'h0;
                else if (a > 16'h8000)
                    a = 16'h8000;
                w = ONE_FX - 2 * longint'(a);
            end
            MODE_CYL:
            begin
                u = turn_of(-t[2], t[0]);
                w = (t[1] + ONE_FX) >>> 1;
            end
            MODE_DISC:
            begin
                u = turn_of(-t[1], t[0]);
                w = dist_of(t[0], t[1]);
            end
            default: ;
        endcase
        u = clamp32(u);
        w = clamp32(w);
        r.tex_u    = u[31:0];
        r.tex_v    = w[31:0];
        r.out_last = v.in_last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vtcm_out_t e;
        if (!rst_n)
        begin
            mode_q <= MODE_NONE;
            mat_q  <= '{64'd65536, 64'd0, 64'd65536, 64'd0, 64'd65536, 64'd0};
            errors <= 0;
            uv_expected.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                    mode_q <= cfg_data[2:0];
                else if (cfg_index >= REG_MAT0 && cfg_index <= REG_MAT5)
                    mat_q[cfg_index - REG_MAT0] <= cfg_data;
            end
            if (push && !full)
                uv_expected.push_back(map_vertex(in_item));
            if (pop && !empty)
            begin
                if (uv_expected.size() == 0)
                begin
                    $display("%0t: unexpected item u=%h v=%h last=%b", $time,
                             out_item.tex_u, out_item.tex_v, out_item.out_last);
                    errors <= errors + 1;
                end
                else
                begin
                    e = uv_expected.pop_front();
                    if (e.tex_u !== out_item.tex_u)
                        $display("%0t: tex_u expected %h actual %h", $time,
                                 e.tex_u, out_item.tex_u);
                    if (e.tex_v !== out_item.tex_v)
                        $display("%0t: tex_v expected %h actual %h", $time,
                                 e.tex_v, out_item.tex_v);
                    if (e.out_last !== out_item.out_last)
                        $display("%0t: out_last expected %b actual %b", $time,
                                 e.out_last, out_item.out_last);
                    if (e !== out_item)
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule

// ===== dv/tb_vertex_texture_coord_mapper_top.sv =====
// testbench top of the texture coordinate mapper: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_vertex_texture_coord_mapper_top;
    import vtcm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    vtcm_in_t    in_item;
    logic        empty;
    logic        pop;
    vtcm_out_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    vertex_texture_coord_mapper_top dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vtcm_checker checker_i (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
        pop = ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word(input int kind);
        case (kind)
            0: return 32'($urandom_range(0, 524287)) - 32'd262144;
            1: return $urandom;
            default:
            begin
                case ($urandom_range(4))
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 32'h00010000;
                    3: return 32'hFFFF0000;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    // called at a falling edge with nothing in flight
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic settle();
        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_vertex(input vtcm_in_t v);
        logic was_full;
        in_item = v;
        push    = 1'b1;
        do
        begin
            was_full = full;
            @(posedge clk);
            @(negedge clk);
        end
        while (was_full);
        while ($urandom_range(99) < idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic load_matrix(input int kind);
        logic [63:0] w;
        for (int r = 0; r < 6; r++)
        begin
            if (kind == 3)
                w = (r % 2 == 0) ? 64'd65536 : 64'd0;
            else
                w = {pick_word(kind), pick_word(kind)};
            write_reg(REG_MAT0 + 3'(r), w);
        end
    endtask

    task automatic send_random(input int count);
        vtcm_in_t v;
        int       kind;
        for (int n = 0; n < count; n++)
        begin
            kind      = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
            v.pos_x   = pick_word(kind);
            v.pos_y   = pick_word(kind);
            v.pos_z   = pick_word(kind);
            v.in_last = $urandom_range(1);
            send_vertex(v);
        end
    endtask

    initial
    begin
        vtcm_in_t    corner [0:5];
        logic [2:0]  dmode  [0:5];
        logic [2:0]  m;
        push         = 1'b0;
        pop          = 1'b0;
        in_item      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_MODE;
        cfg_data     = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // origin, unit axes and field extremes
        corner[0] = '{32'sh0, 32'sh0, 32'sh0, 1'b1};
        corner[1] = '{32'sh00010000, 32'sh0, 32'sh0, 1'b0};
        corner[2] = '{-32'sh00010000, 32'sh0, 32'sh0, 1'b1};
        corner[3] = '{32'sh0, 32'sh00010000, -32'sh00010000, 1'b0};
        corner[4] = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1};
        corner[5] = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0};
        dmode = '{MODE_NONE, MODE_PLANAR, MODE_SPHERE, MODE_CYL, MODE_DISC, 3'd7};
        for (int k = 0; k < 6; k++)
        begin
            settle();
            write_reg(REG_MODE, dmode[k]);
            for (int c = 0; c < 4; c++)
                send_vertex(corner[(k + c) % 6]);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            for (int seg = 0; seg < 6; seg++)
            begin
                settle();
                m = $urandom_range(9) < 8 ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
                write_reg(REG_MODE, m);
                load_matrix(seg < 2 ? 0 : (seg == 2 ? 3 : $urandom_range(2)));
                send_random(22);
            end
        end

        push = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
